FILE: hw/rtl/acpwr_pkg.sv
// Shared constants, widths and the sequencer state type for the
// two-channel AC power block. No dependencies.
`default_nettype none

package acpwr_pkg;

    localparam int WINDOW_LEN = 53;
    localparam int SAMPLE_W   = 12;
    localparam int FRAC_W     = 16;
    localparam int POS_W      = $clog2(WINDOW_LEN);
    localparam int ADDR_W     = POS_W + 1;
    localparam int RAM_DEPTH  = 2 ** ADDR_W;

    localparam int LEVEL_W = 29;
    localparam int NUM_W   = 36;
    localparam int T_W     = 32;
    localparam int Q_W     = 28;
    localparam int DIFF_W  = 30;
    localparam int SQ_W    = 2 * SAMPLE_W;
    localparam int SUM_W   = 30;
    localparam int U_W     = SUM_W - 1;
    localparam int TEN_W   = 27;
    localparam int CFG_W   = 8;

    localparam logic signed [NUM_W-1:0] KEEP_WEIGHT = 36'sd199;

    // x/200 = (x>>3)/25, x/10 = (x>>1)/5 via reciprocal and one fix-up
    localparam logic [T_W-1:0] DIV25       = 32'd25;
    localparam logic [T_W-1:0] DIV25_RECIP = 32'd2748779069;
    localparam int             DIV25_SHIFT = 36;
    localparam logic [U_W-1:0] DIV5        = 29'd5;
    localparam logic [T_W-1:0] DIV5_RECIP  = 32'd3435973836;
    localparam int             DIV5_SHIFT  = 34;

    localparam logic CFG_STEADY = 1'b0;
    localparam logic CFG_MARGIN = 1'b1;

    localparam logic [CFG_W-1:0] STEADY_RESET = 8'd71;
    localparam logic [CFG_W-1:0] MARGIN_RESET = 8'd5;

    typedef enum logic [10:0] {
        ST_CLEAR = 11'b000_0000_0001,
        ST_IDLE  = 11'b000_0000_0010,
        ST_ABS   = 11'b000_0000_0100,
        ST_MUL   = 11'b000_0000_1000,
        ST_FIX   = 11'b000_0001_0000,
        ST_DEV   = 11'b000_0010_0000,
        ST_SQ    = 11'b000_0100_0000,
        ST_SUM   = 11'b000_1000_0000,
        ST_TEN1  = 11'b001_0000_0000,
        ST_TEN2  = 11'b010_0000_0000,
        ST_CALM  = 11'b100_0000_0000
    } t_state;

endpackage

`default_nettype wire

FILE: hw/rtl/acpwr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module acpwr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hw/rtl/acpwr_dev.sv
// DC level tracker: level update with divide by 200, deviation and square.
// Depends on acpwr_pkg; stepped by the top-level sequencer state.
`default_nettype none

module acpwr_dev
    import acpwr_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_state                     i_state,
    input  wire logic                       i_load,
    input  wire logic                       i_channel,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    output logic                            o_channel,
    output logic             [SQ_W-1:0]     o_sq
);

    logic signed [LEVEL_W-1:0]  r_level [2];
    logic                       r_ch;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic signed [NUM_W-1:0]    r_num;
    logic                       r_neg;
    logic        [T_W-1:0]      r_t;
    logic        [Q_W-1:0]      r_q;
    logic signed [DIFF_W-1:0]   r_diff;
    logic        [SQ_W-1:0]     r_sq;

    logic signed [NUM_W-1:0]    w_num;
    logic        [NUM_W-1:0]    w_mag;
    logic        [2*T_W-1:0]    w_prod;
    logic        [T_W-1:0]      w_q25;
    logic        [T_W-1:0]      w_rem;
    logic signed [LEVEL_W-1:0]  w_qx;
    logic signed [LEVEL_W-1:0]  w_lvl;
    logic signed [DIFF_W-1:0]   w_sfx;
    logic signed [DIFF_W-1:0]   w_qd;
    logic        [DIFF_W-1:0]   w_dmag;
    logic        [SAMPLE_W-1:0] w_dev;

    assign w_num  = NUM_W'(r_level[i_channel]) * KEEP_WEIGHT
                  + (NUM_W'(i_sample) <<< FRAC_W);
    assign w_mag  = r_num[NUM_W-1] ? NUM_W'(-r_num) : NUM_W'(r_num);
    assign w_prod = {{T_W{1'b0}}, r_t} * {{T_W{1'b0}}, DIV25_RECIP};
    assign w_q25  = T_W'(r_q) * DIV25;
    assign w_rem  = r_t - w_q25;
    assign w_qx   = {1'b0, r_q};
    assign w_lvl  = r_neg ? -w_qx : w_qx;
    assign w_sfx  = DIFF_W'(r_sample) <<< FRAC_W;
    assign w_qd   = {2'b00, r_q};
    assign w_dmag = r_diff[DIFF_W-1] ? DIFF_W'(-r_diff) : DIFF_W'(r_diff);
    assign w_dev  = w_dmag[FRAC_W+SAMPLE_W-1:FRAC_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level[0] <= '0;
            r_level[1] <= '0;
            r_ch       <= 1'b0;
        end else begin
            if (i_load) begin
                r_ch <= i_channel;
            end
            if (i_state == ST_DEV) begin
                r_level[r_ch] <= w_lvl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sample <= i_sample;
            r_num    <= w_num;
        end
        unique case (i_state)
            ST_ABS: begin
                r_neg <= r_num[NUM_W-1];
                r_t   <= w_mag[T_W+2:3];
            end
            ST_MUL: begin
                r_q <= w_prod[DIV25_SHIFT+Q_W-1:DIV25_SHIFT];
            end
            ST_FIX: begin
                if (w_rem >= DIV25) begin
                    r_q <= r_q + 1'b1;
                end
            end
            ST_DEV: begin
                r_diff <= r_neg ? w_sfx + w_qd : w_sfx - w_qd;
            end
            ST_SQ: begin
                r_sq <= SQ_W'(w_dev) * SQ_W'(w_dev);
            end
            default: begin
            end
        endcase
    end

    assign o_channel = r_ch;
    assign o_sq      = r_sq;

endmodule

`default_nettype wire

FILE: hw/rtl/two_channel_ac_power_with_stability.sv
// Top level: sequencer, window memory, running sums and stability counter.
// Depends on acpwr_pkg, acpwr_ram and acpwr_dev.
//
// Each accepted word runs through the sequencer states ABS, MUL, FIX, DEV, SQ,
// SUM, TEN1, TEN2 and CALM before its result is registered, and the next word
// is taken only when that sequence is done; the states hold the divide-by-200
// level update, squaring, window read-modify-write and the divide-by-10 margin.
// A finished result waits in an output register, so a new word is taken while
// it is still stalled. After reset all 128 window memory entries are cleared,
// while input stays stalled; configuration writes are taken at any time.
`default_nettype none

module two_channel_ac_power_with_stability
    import acpwr_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic                       i_channel,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic                            o_channel_out,
    output logic             [SUM_W-1:0]    o_sum_first,
    output logic             [SUM_W-1:0]    o_sum_second,
    output logic                            o_stable,
    input  wire logic                       i_cfg_we,
    input  wire logic                       i_cfg_idx,
    input  wire logic        [CFG_W-1:0]    i_cfg_data
);

    t_state r_state;
    t_state n_state;

    logic [ADDR_W-1:0] r_clr_addr;
    logic [POS_W-1:0]  r_pos    [2];
    logic [SUM_W-1:0]  r_sum    [2];
    logic [SUM_W-1:0]  r_prev   [2];
    logic [TEN_W-1:0]  r_tenth  [2];
    logic [TEN_W-1:0]  r_q10;
    logic [CFG_W-1:0]  r_count;
    logic [CFG_W-1:0]  r_steady;
    logic [CFG_W-1:0]  r_margin;

    logic              r_out_valid;
    logic              r_out_ch;
    logic [SUM_W-1:0]  r_out_sum0;
    logic [SUM_W-1:0]  r_out_sum1;
    logic              r_out_stable;

    logic              w_accept;
    logic              w_out_free;
    logic              w_done;
    logic              w_ch;
    logic [SQ_W-1:0]   w_sq;
    logic [SQ_W-1:0]   w_old;
    logic [SUM_W-1:0]  w_new_sum;
    logic [U_W-1:0]    w_u;
    logic [2*T_W-1:0]  w_prod10;
    logic [U_W-1:0]    w_q5;
    logic [U_W-1:0]    w_rem10;
    logic [1:0]        w_calm;
    logic [CFG_W-1:0]  n_count;

    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [SQ_W-1:0]   w_wdata;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && (r_state == ST_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_done     = (r_state == ST_CALM) && w_out_free;

    acpwr_dev u_dev (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_state   (r_state),
        .i_load    (w_accept),
        .i_channel (i_channel),
        .i_sample  (i_sample),
        .o_channel (w_ch),
        .o_sq      (w_sq)
    );

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_clr_addr;
        w_wdata = '0;
        if (r_state == ST_CLEAR) begin
            w_we = 1'b1;
        end else if (r_state == ST_SUM) begin
            w_we    = 1'b1;
            w_waddr = {w_ch, r_pos[w_ch]};
            w_wdata = w_sq;
        end
    end

    acpwr_ram #(
        .WIDTH (SQ_W),
        .DEPTH (RAM_DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_accept),
        .i_raddr ({i_channel, r_pos[i_channel]}),
        .o_rdata (w_old)
    );

    assign w_new_sum = r_sum[w_ch] - SUM_W'(w_old) + SUM_W'(w_sq);
    assign w_u       = r_sum[w_ch][SUM_W-1:1];
    assign w_prod10  = {{(2*T_W-U_W){1'b0}}, w_u} * {{T_W{1'b0}}, DIV5_RECIP};
    assign w_q5      = U_W'(r_q10) * DIV5;
    assign w_rem10   = w_u - w_q5;

    for (genvar g = 0; g < 2; g++) begin : g_calm
        logic [SUM_W-1:0] w_diff;
        logic [SUM_W:0]   w_lim;
        assign w_diff = (r_sum[g] > r_prev[g]) ? r_sum[g] - r_prev[g]
                                               : r_prev[g] - r_sum[g];
        assign w_lim  = (SUM_W+1)'(r_tenth[g]) + (SUM_W+1)'(r_margin);
        assign w_calm[g] = ({1'b0, w_diff} < w_lim);
    end

    always_comb begin
        if (w_calm[0] && w_calm[1]) begin
            n_count = (r_count < r_steady) ? r_count + 1'b1 : r_count;
        end else begin
            n_count = '0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (&r_clr_addr) n_state = ST_IDLE;
            ST_IDLE:  if (w_accept) n_state = ST_ABS;
            ST_ABS:   n_state = ST_MUL;
            ST_MUL:   n_state = ST_FIX;
            ST_FIX:   n_state = ST_DEV;
            ST_DEV:   n_state = ST_SQ;
            ST_SQ:    n_state = ST_SUM;
            ST_SUM:   n_state = ST_TEN1;
            ST_TEN1:  n_state = ST_TEN2;
            ST_TEN2:  n_state = ST_CALM;
            ST_CALM:  if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_pos[0]    <= '0;
            r_pos[1]    <= '0;
            r_sum[0]    <= '0;
            r_sum[1]    <= '0;
            r_prev[0]   <= '0;
            r_prev[1]   <= '0;
            r_tenth[0]  <= '0;
            r_tenth[1]  <= '0;
            r_count     <= '0;
            r_steady    <= STEADY_RESET;
            r_margin    <= MARGIN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_STEADY: r_steady <= i_cfg_data;
                    CFG_MARGIN: r_margin <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (r_state == ST_SUM) begin
                r_sum[w_ch] <= w_new_sum;
                r_pos[w_ch] <= (r_pos[w_ch] == POS_W'(WINDOW_LEN - 1))
                             ? '0 : r_pos[w_ch] + 1'b1;
            end
            if (r_state == ST_TEN2) begin
                r_tenth[w_ch] <= (w_rem10 >= DIV5) ? r_q10 + 1'b1 : r_q10;
            end
            if (w_done) begin
                r_prev[0] <= r_sum[0];
                r_prev[1] <= r_sum[1];
                r_count   <= n_count;
            end
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_TEN1) begin
            r_q10 <= w_prod10[DIV5_SHIFT+TEN_W-1:DIV5_SHIFT];
        end
        if (w_done) begin
            r_out_ch     <= w_ch;
            r_out_sum0   <= r_sum[0];
            r_out_sum1   <= r_sum[1];
            r_out_stable <= (n_count >= r_steady);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_channel_out = r_out_ch;
    assign o_sum_first   = r_out_sum0;
    assign o_sum_second  = r_out_sum1;
    assign o_stable      = r_out_stable;

endmodule

`default_nettype wire
